>>> rtl/xdwm_pkg.sv
package xdwm_pkg;

    localparam int STICK_W    = 8;
    localparam int GAIN_W     = 8;
    localparam int MV_W       = 16;
    localparam int LANES      = 4;
    localparam int PCT_FULL   = 100;
    localparam int GAIN_RESET = 94;
    localparam int SCALE_W    = 15;
    localparam int MAG_W      = 17;
    localparam int NUM_W      = 18;
    localparam int PROD_W     = 32;
    localparam int NUMER_W    = 31;
    localparam int QUO_W      = 15;
    localparam int DIV_STAGES = QUO_W;

    localparam int LANE_FL = 0;
    localparam int LANE_BL = 1;
    localparam int LANE_FR = 2;
    localparam int LANE_BR = 3;

    typedef struct packed {
        logic signed [STICK_W-1:0] forward_stick;
        logic signed [STICK_W-1:0] strafe_stick;
        logic signed [STICK_W-1:0] turn_stick;
    } in_word_t;

    typedef struct packed {
        logic signed [MV_W-1:0] front_left_mv;
        logic signed [MV_W-1:0] back_left_mv;
        logic signed [MV_W-1:0] front_right_mv;
        logic signed [MV_W-1:0] back_right_mv;
    } out_word_t;

    typedef struct packed {
        logic signed [STICK_W:0]   sum_fs;
        logic signed [STICK_W:0]   dif_fs;
        logic signed [STICK_W-1:0] turn;
        logic [STICK_W-1:0]        m;
        logic [STICK_W:0]          d;
    } s1_t;

    typedef struct packed {
        logic [LANES-1:0][NUM_W-1:0] n;
        logic [MAG_W-1:0]            lim0;
    } s2_t;

    typedef struct packed {
        logic [LANES-1:0][MAG_W-1:0] mag;
        logic [LANES-1:0]            neg;
        logic [MAG_W-1:0]            max01;
        logic [MAG_W-1:0]            max23;
        logic [MAG_W-1:0]            lim0;
    } s3_t;

    typedef struct packed {
        logic [LANES-1:0][NUMER_W-1:0] rem;
        logic [LANES-1:0][QUO_W-1:0]   quo;
        logic [LANES-1:0]              neg;
        logic [MAG_W-1:0]              lim;
    } div_t;

endpackage

>>> rtl/x_drive_wheel_mixer_top.sv
// X-drive wheel mixer. Takes one stick sample (forward, strafe, turn) per
// word and returns one word of four wheel commands in millivolts, exact to
// truncation toward zero. Fully pipelined: one sample per clock while no
// stage is stalled (4 mixing stages, 15 divider stages that each retire one
// quotient bit for all four wheels, 1 output stage). Every stage holds its
// own word and stalls only when the stage after it is full, so bubbles close
// up and samples keep entering while a finished word waits at the output.
// output_gain is written through cfg_we/cfg_wdata (reset 94) and must be
// written only while no sample is in flight.
module x_drive_wheel_mixer_top import xdwm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [GAIN_W-1:0] cfg_wdata,
    input  logic              sample_valid,
    output logic              sample_ready,
    input  in_word_t          sample,
    output logic              wheel_valid,
    input  logic              wheel_ready,
    output out_word_t         wheel
);

    logic [SCALE_W-1:0] scale_reg, scale_next;
    logic               wheel_valid_reg, wheel_valid_next;
    out_word_t          wheel_reg, wheel_next;

    logic               div_valid [0:DIV_STAGES];
    logic               div_ready [0:DIV_STAGES];
    div_t               div_word  [0:DIV_STAGES];

    assign scale_next = SCALE_W'(cfg_wdata) * SCALE_W'(PCT_FULL);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg <= SCALE_W'(GAIN_RESET * PCT_FULL);
        end
        else if (cfg_we)
        begin
            scale_reg <= scale_next;
        end
    end

    xdwm_mix u_mix
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (sample_valid),
        .up_ready (sample_ready),
        .up_word  (sample),
        .scale    (scale_reg),
        .dn_valid (div_valid[0]),
        .dn_ready (div_ready[0]),
        .dn_word  (div_word[0])
    );

    for (genvar j = 0; j < DIV_STAGES; j++)
    begin : g_div
        xdwm_div_step #(.BIT(DIV_STAGES - 1 - j)) u_step
        (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (div_valid[j]),
            .up_ready (div_ready[j]),
            .up_word  (div_word[j]),
            .dn_valid (div_valid[j+1]),
            .dn_ready (div_ready[j+1]),
            .dn_word  (div_word[j+1])
        );
    end

    // apply signs and hold the result word
    assign div_ready[DIV_STAGES] = !wheel_valid_reg || wheel_ready;
    assign wheel_valid_next = div_ready[DIV_STAGES] ? div_valid[DIV_STAGES] : wheel_valid_reg;

    always_comb
    begin
        logic signed [MV_W-1:0] q [0:LANES-1];
        for (int k = 0; k < LANES; k++)
        begin
            q[k] = $signed(MV_W'(div_word[DIV_STAGES].quo[k]));
            if (div_word[DIV_STAGES].neg[k])
            begin
                q[k] = -q[k];
            end
        end
        wheel_next.front_left_mv  = q[LANE_FL];
        wheel_next.back_left_mv   = q[LANE_BL];
        wheel_next.front_right_mv = q[LANE_FR];
        wheel_next.back_right_mv  = q[LANE_BR];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wheel_valid_reg <= 1'b0;
        end
        else
        begin
            wheel_valid_reg <= wheel_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (div_ready[DIV_STAGES] && div_valid[DIV_STAGES])
        begin
            wheel_reg <= wheel_next;
        end
    end

    assign wheel_valid = wheel_valid_reg;
    assign wheel       = wheel_reg;

`ifndef SYNTHESIS
    a_full_scale: assert property (@(posedge clk) disable iff (!rst_n)
        wheel_valid_reg |->
            ($signed(wheel_reg.front_left_mv)  <=  $signed({2'b0, scale_reg})) &&
            ($signed(wheel_reg.front_left_mv)  >= -$signed({2'b0, scale_reg})) &&
            ($signed(wheel_reg.back_left_mv)   <=  $signed({2'b0, scale_reg})) &&
            ($signed(wheel_reg.back_left_mv)   >= -$signed({2'b0, scale_reg})) &&
            ($signed(wheel_reg.front_right_mv) <=  $signed({2'b0, scale_reg})) &&
            ($signed(wheel_reg.front_right_mv) >= -$signed({2'b0, scale_reg})) &&
            ($signed(wheel_reg.back_right_mv)  <=  $signed({2'b0, scale_reg})) &&
            ($signed(wheel_reg.back_right_mv)  >= -$signed({2'b0, scale_reg})))
        else $error("wheel command beyond full scale");

    a_zero_gain: assert property (@(posedge clk) disable iff (!rst_n)
        (wheel_valid_reg && (scale_reg == '0)) |->
            (wheel_reg.front_left_mv == '0) && (wheel_reg.back_left_mv == '0) &&
            (wheel_reg.front_right_mv == '0) && (wheel_reg.back_right_mv == '0))
        else $error("nonzero command at zero gain");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (div_valid[DIV_STAGES] && !div_ready[DIV_STAGES]) |=> div_valid[DIV_STAGES])
        else $error("divider word lost while output stalled");
`endif

endmodule

>>> rtl/xdwm_mix.sv
module xdwm_mix import xdwm_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               up_valid,
    output logic               up_ready,
    input  in_word_t           up_word,
    input  logic [SCALE_W-1:0] scale,
    output logic               dn_valid,
    input  logic               dn_ready,
    output div_t               dn_word
);

    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    logic s1_valid_next, s2_valid_next, s3_valid_next, s4_valid_next;
    logic rdy1, rdy2, rdy3, rdy4;
    s1_t  s1_reg, s1_next;
    s2_t  s2_reg, s2_next;
    s3_t  s3_reg, s3_next;
    div_t s4_reg, s4_next;

    logic signed [STICK_W:0] f9, s9, af9, as9;
    logic [STICK_W-1:0]      af, as;
    logic signed [NUM_W-1:0] p_sum, p_dif, td;

    assign rdy4     = !s4_valid_reg || dn_ready;
    assign rdy3     = !s3_valid_reg || rdy4;
    assign rdy2     = !s2_valid_reg || rdy3;
    assign rdy1     = !s1_valid_reg || rdy2;
    assign up_ready = rdy1;
    assign dn_valid = s4_valid_reg;
    assign dn_word  = s4_reg;

    assign s1_valid_next = rdy1 ? up_valid     : s1_valid_reg;
    assign s2_valid_next = rdy2 ? s1_valid_reg : s2_valid_reg;
    assign s3_valid_next = rdy3 ? s2_valid_reg : s3_valid_reg;
    assign s4_valid_next = rdy4 ? s3_valid_reg : s4_valid_reg;

    // magnitudes, translation terms, rescale factor
    assign f9  = (STICK_W+1)'(up_word.forward_stick);
    assign s9  = (STICK_W+1)'(up_word.strafe_stick);
    assign af9 = f9[STICK_W] ? -f9 : f9;
    assign as9 = s9[STICK_W] ? -s9 : s9;
    assign af  = af9[STICK_W-1:0];
    assign as  = as9[STICK_W-1:0];

    always_comb
    begin
        s1_next.sum_fs = f9 + s9;
        s1_next.dif_fs = f9 - s9;
        s1_next.turn   = up_word.turn_stick;
        s1_next.m      = (af > as) ? af : as;
        s1_next.d      = (STICK_W+1)'(af) + (STICK_W+1)'(as);
        if (s1_next.d == '0)
        begin
            s1_next.m = STICK_W'(1);
            s1_next.d = (STICK_W+1)'(1);
        end
    end

    // wheel numerators
    assign p_sum = $signed(s1_reg.sum_fs) * $signed({1'b0, s1_reg.m});
    assign p_dif = $signed(s1_reg.dif_fs) * $signed({1'b0, s1_reg.m});
    assign td    = $signed(s1_reg.turn) * $signed({1'b0, s1_reg.d});

    always_comb
    begin
        s2_next.n[LANE_FL] = p_sum + td;
        s2_next.n[LANE_BL] = p_dif + td;
        s2_next.n[LANE_FR] = p_dif - td;
        s2_next.n[LANE_BR] = p_sum - td;
        s2_next.lim0       = MAG_W'(s1_reg.d) * MAG_W'(PCT_FULL);
    end

    // magnitudes and first level of the limit search
    always_comb
    begin
        logic signed [NUM_W-1:0] nk;
        logic signed [NUM_W-1:0] ak;
        s3_next      = '0;
        s3_next.lim0 = s2_reg.lim0;
        for (int k = 0; k < LANES; k++)
        begin
            nk             = $signed(s2_reg.n[k]);
            ak             = nk[NUM_W-1] ? -nk : nk;
            s3_next.mag[k] = ak[MAG_W-1:0];
            s3_next.neg[k] = nk[NUM_W-1];
        end
        s3_next.max01 = (s3_next.mag[0] > s3_next.mag[1]) ? s3_next.mag[0] : s3_next.mag[1];
        s3_next.max23 = (s3_next.mag[2] > s3_next.mag[3]) ? s3_next.mag[2] : s3_next.mag[3];
    end

    // scaled dividends and final limit
    always_comb
    begin
        logic [PROD_W-1:0] prod;
        logic [MAG_W-1:0]  mx;
        s4_next     = '0;
        s4_next.neg = s3_reg.neg;
        for (int k = 0; k < LANES; k++)
        begin
            prod           = PROD_W'(s3_reg.mag[k]) * PROD_W'(scale);
            s4_next.rem[k] = prod[NUMER_W-1:0];
        end
        mx          = (s3_reg.max01 > s3_reg.max23) ? s3_reg.max01 : s3_reg.max23;
        s4_next.lim = (mx > s3_reg.lim0) ? mx : s3_reg.lim0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
            s3_valid_reg <= s3_valid_next;
            s4_valid_reg <= s4_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1 && up_valid)
        begin
            s1_reg <= s1_next;
        end
        if (rdy2 && s1_valid_reg)
        begin
            s2_reg <= s2_next;
        end
        if (rdy3 && s2_valid_reg)
        begin
            s3_reg <= s3_next;
        end
        if (rdy4 && s3_valid_reg)
        begin
            s4_reg <= s4_next;
        end
    end

`ifndef SYNTHESIS
    a_lim_floor: assert property (@(posedge clk) disable iff (!rst_n)
        s4_valid_reg |-> (s4_reg.lim >= MAG_W'(PCT_FULL)))
        else $error("limit below full scale");
`endif

endmodule

>>> rtl/xdwm_div_step.sv
module xdwm_div_step import xdwm_pkg::*;
#(
    parameter int unsigned BIT = QUO_W - 1
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic up_valid,
    output logic up_ready,
    input  div_t up_word,
    output logic dn_valid,
    input  logic dn_ready,
    output div_t dn_word
);

    logic               valid_reg, valid_next;
    div_t               word_reg, word_next;
    logic [NUMER_W-1:0] shifted;

    assign shifted  = NUMER_W'(up_word.lim) << BIT;
    assign up_ready = !valid_reg || dn_ready;
    assign dn_valid = valid_reg;
    assign dn_word  = word_reg;

    assign valid_next = up_ready ? up_valid : valid_reg;

    always_comb
    begin
        word_next = up_word;
        for (int k = 0; k < LANES; k++)
        begin
            if (up_word.rem[k] >= shifted)
            begin
                word_next.rem[k]      = up_word.rem[k] - shifted;
                word_next.quo[k][BIT] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            word_reg <= word_next;
        end
    end

`ifndef SYNTHESIS
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |->
            (word_reg.rem[0] < (NUMER_W'(word_reg.lim) << BIT)) &&
            (word_reg.rem[1] < (NUMER_W'(word_reg.lim) << BIT)) &&
            (word_reg.rem[2] < (NUMER_W'(word_reg.lim) << BIT)) &&
            (word_reg.rem[3] < (NUMER_W'(word_reg.lim) << BIT)))
        else $error("partial remainder out of range");
`endif

endmodule
